[sv/poly_voice_allocator_envelope_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the voice allocator.
// Every check is clocked on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POLY_VOICE_ALLOCATOR_ENVELOPE_TOP_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_ENVELOPE_TOP_MACROS_SVH

// A free-form property.
`define PVAE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A same-cycle implication.
`define PVAE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/pvae_pkg.sv]
// ----------------------------------------------------------------------------
// pvae_pkg
// Shared types and constants of the voice allocator and envelope engine.
// ----------------------------------------------------------------------------
package pvae_pkg;

    localparam int VOICE_COUNT_DEFAULT = 8;
    localparam int MAX_REPORT          = 8;
    localparam int CMD_FIFO_DEPTH      = 2;
    localparam int CFG_INDEX_W         = 3;

    localparam logic [15:0] LEVEL_ONE = 16'h8000;
    localparam logic [16:0] BUSY_FULL = 17'h10000;
    localparam logic [16:0] BUSY_INIT = 17'h10001;

    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_STEP   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_COEFF   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_COEFF = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFF_THRESHOLD = 3'd4;

    localparam logic [15:0] ATTACK_STEP_RST   = 16'd8;
    localparam logic [15:0] DECAY_COEFF_RST   = 16'd65500;
    localparam logic [15:0] RELEASE_COEFF_RST = 16'd65500;
    localparam logic [15:0] SUSTAIN_LEVEL_RST = 16'd16384;
    localparam logic [15:0] OFF_THRESHOLD_RST = 16'd16;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        EG_OFF     = 2'd0,
        EG_ATTACK  = 2'd1,
        EG_HOLD    = 2'd2,
        EG_RELEASE = 2'd3
    } env_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] note;
        logic [6:0] velocity;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  note;
        logic [6:0]  velocity;
        env_t        state;
        logic [15:0] level;
    } voice_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

[sv/pvae_front.sv]
// ----------------------------------------------------------------------------
// pvae_front
// Input register: accepts events, decodes the kind and hands commands on.
// ----------------------------------------------------------------------------
module pvae_front
    import pvae_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   kind,
    input  logic [6:0]   note,
    input  logic [6:0]   velocity,
    input  fifo_status_t status,
    output logic         push,
    output cmd_t         cmd
);

    logic cmd_valid_reg;
    logic cmd_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;

    assign push     = cmd_valid_reg && !status.full;
    assign in_stall = cmd_valid_reg && status.full;
    assign accept   = in_valid && !in_stall;
    assign cmd      = cmd_reg;

    always_comb
    begin
        cmd_next.note     = note;
        cmd_next.velocity = velocity;
        unique case (kind)
            KIND_TICK:     cmd_next.op = OP_TICK;
            KIND_NOTE_ON:  cmd_next.op = OP_NOTE_ON;
            KIND_NOTE_OFF: cmd_next.op = OP_NOTE_OFF;
            default:       cmd_next.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (push)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

[sv/pvae_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// pvae_cmd_fifo
// Short command queue that decouples the input side from the voice engine.
// ----------------------------------------------------------------------------
module pvae_cmd_fifo
    import pvae_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  cmd_t         push_data,
    input  logic         pop,
    output cmd_t         pop_data,
    output fifo_status_t status
);

    localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMD_FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMD_FIFO_DEPTH);

    cmd_t             entry_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/pvae_back.sv]
// ----------------------------------------------------------------------------
// pvae_back
// Voice engine: configuration registers, voice memory, result register and a
// sequencer for ticks and voice searches, one voice per cycle unless a tick stalls.
// ----------------------------------------------------------------------------
`include "poly_voice_allocator_envelope_top_macros.svh"

module pvae_back
    import pvae_pkg::*;
#(
    parameter int VOICE_COUNT = VOICE_COUNT_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    input  fifo_status_t           status,
    output logic                   pop,
    input  cmd_t                   cmd,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             voice_index,
    output logic                   found,
    output logic [6:0]             voice_note,
    output logic [6:0]             voice_velocity,
    output logic [1:0]             env_state,
    output logic [15:0]            env_level,
    output logic                   last
);

    localparam int VIDX_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int REPORT_COUNT = (VOICE_COUNT < MAX_REPORT) ? VOICE_COUNT : MAX_REPORT;
    localparam logic [VIDX_W-1:0] LAST_VOICE  = VIDX_W'(VOICE_COUNT - 1);
    localparam logic [VIDX_W-1:0] LAST_REPORT = VIDX_W'(REPORT_COUNT - 1);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_TICK     = 5'b00010,
        S_SCAN_ON  = 5'b00100,
        S_SCAN_OFF = 5'b01000,
        S_COMMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic [VIDX_W-1:0] v_reg;
    logic [VIDX_W-1:0] v_next;

    logic [15:0] attack_step_reg;
    logic [15:0] decay_coeff_reg;
    logic [15:0] release_coeff_reg;
    logic [15:0] sustain_level_reg;
    logic [15:0] off_threshold_reg;

    op_t         op_reg;
    logic [6:0]  note_reg;
    logic [6:0]  vel_reg;
    logic [16:0] best_reg;
    logic [VIDX_W-1:0] pick_reg;
    logic        hit_reg;
    logic [VIDX_W-1:0] hit_idx_reg;
    voice_t      hit_rec_reg;

    voice_t            voice_mem [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] valid_reg;
    voice_t            rd_data_reg;
    logic              rd_valid_reg;
    logic              rd_en;
    logic [VIDX_W-1:0] rd_addr;
    logic              we;
    logic [VIDX_W-1:0] wr_addr;
    voice_t            wr_data;

    voice_t            rec;
    voice_t            stepped;
    logic [16:0]       attack_sum;
    logic signed [17:0] diff;
    logic [15:0]       mag;
    logic [15:0]       mul_a;
    logic [15:0]       mul_b;
    logic [31:0]       product;
    logic [15:0]       prod_hi;
    logic signed [18:0] hold_res;
    logic [16:0]       busy;
    logic              better;
    logic              match;
    logic              report;

    logic              out_free;
    logic              emit;
    voice_t            emit_rec;
    logic [VIDX_W-1:0] emit_idx;
    logic              emit_found;
    logic              emit_last;

    logic              out_valid_reg;
    logic [2:0]        voice_index_reg;
    logic              found_reg;
    logic [6:0]        voice_note_reg;
    logic [6:0]        voice_velocity_reg;
    env_t              env_state_reg;
    logic [15:0]       env_level_reg;
    logic              last_reg;

    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign voice_index    = voice_index_reg;
    assign found          = found_reg;
    assign voice_note     = voice_note_reg;
    assign voice_velocity = voice_velocity_reg;
    assign env_state      = env_state_reg;
    assign env_level      = env_level_reg;
    assign last           = last_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign rec      = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_step_reg   <= ATTACK_STEP_RST;
            decay_coeff_reg   <= DECAY_COEFF_RST;
            release_coeff_reg <= RELEASE_COEFF_RST;
            sustain_level_reg <= SUSTAIN_LEVEL_RST;
            off_threshold_reg <= OFF_THRESHOLD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ATTACK_STEP:   attack_step_reg   <= cfg_data;
                CFG_DECAY_COEFF:   decay_coeff_reg   <= cfg_data;
                CFG_RELEASE_COEFF: release_coeff_reg <= cfg_data;
                CFG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_data;
                CFG_OFF_THRESHOLD: off_threshold_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        attack_sum = {1'b0, rec.level} + {1'b0, attack_step_reg};
        diff       = $signed({2'b00, rec.level}) - $signed({2'b00, sustain_level_reg});
        mag        = diff[17] ? 16'(-diff) : diff[15:0];
        mul_a      = (rec.state == EG_HOLD) ? mag : rec.level;
        mul_b      = (rec.state == EG_HOLD) ? decay_coeff_reg : release_coeff_reg;
        product    = mul_a * mul_b;
        prod_hi    = product[31:16];
        if (diff[17])
        begin
            hold_res = $signed({3'b000, sustain_level_reg}) - $signed({3'b000, prod_hi});
        end
        else
        begin
            hold_res = $signed({3'b000, sustain_level_reg}) + $signed({3'b000, prod_hi});
        end

        stepped = rec;
        unique case (rec.state)
            EG_ATTACK:
            begin
                if (attack_sum > {1'b0, LEVEL_ONE})
                begin
                    stepped.level = LEVEL_ONE;
                    stepped.state = EG_HOLD;
                end
                else
                begin
                    stepped.level = attack_sum[15:0];
                end
            end
            EG_HOLD:
            begin
                if (hold_res[18])
                begin
                    stepped.level = '0;
                end
                else if (hold_res > $signed({3'b000, LEVEL_ONE}))
                begin
                    stepped.level = LEVEL_ONE;
                end
                else
                begin
                    stepped.level = hold_res[15:0];
                end
            end
            EG_RELEASE:
            begin
                if (prod_hi < off_threshold_reg)
                begin
                    stepped.level = '0;
                    stepped.state = EG_OFF;
                end
                else
                begin
                    stepped.level = prod_hi;
                end
            end
            default:
            begin
                stepped = rec;
            end
        endcase
    end

    always_comb
    begin
        case (rec.state)
            EG_OFF:     busy = '0;
            EG_RELEASE: busy = {1'b0, rec.level};
            default:    busy = BUSY_FULL;
        endcase
        better = busy < best_reg;
        match  = (rec.note == note_reg) &&
                 ((rec.state == EG_ATTACK) || (rec.state == EG_HOLD));
        report = (v_reg <= LAST_REPORT);
    end

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = VIDX_W'(v_reg + 1'b1);
        we         = 1'b0;
        wr_addr    = v_reg;
        wr_data    = stepped;
        emit       = 1'b0;
        emit_rec   = '0;
        emit_idx   = '0;
        emit_found = 1'b0;
        emit_last  = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!status.empty)
                begin
                    pop     = 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    v_next  = '0;
                    unique case (cmd.op)
                        OP_TICK:     state_next = S_TICK;
                        OP_NOTE_ON:  state_next = S_SCAN_ON;
                        OP_NOTE_OFF: state_next = S_SCAN_OFF;
                        default:     state_next = S_COMMIT;
                    endcase
                end
            end
            S_TICK:
            begin
                if (!report || out_free)
                begin
                    we         = 1'b1;
                    emit       = report;
                    emit_rec   = stepped;
                    emit_idx   = v_reg;
                    emit_found = 1'b1;
                    emit_last  = (v_reg == LAST_REPORT);
                    if (v_reg == LAST_VOICE)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        v_next = VIDX_W'(v_reg + 1'b1);
                        rd_en  = 1'b1;
                    end
                end
            end
            S_SCAN_ON,
            S_SCAN_OFF:
            begin
                if (v_reg == LAST_VOICE)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    v_next = VIDX_W'(v_reg + 1'b1);
                    rd_en  = 1'b1;
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_NOTE_ON:
                        begin
                            we             = 1'b1;
                            wr_addr        = pick_reg;
                            wr_data.note     = note_reg;
                            wr_data.velocity = vel_reg;
                            wr_data.state    = EG_ATTACK;
                            wr_data.level    = '0;
                            emit_rec       = wr_data;
                            emit_idx       = pick_reg;
                            emit_found     = 1'b1;
                        end
                        OP_NOTE_OFF:
                        begin
                            if (hit_reg)
                            begin
                                we            = 1'b1;
                                wr_addr       = hit_idx_reg;
                                wr_data       = hit_rec_reg;
                                wr_data.state = EG_RELEASE;
                                emit_rec      = wr_data;
                                emit_idx      = hit_idx_reg;
                                emit_found    = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit_found = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            v_reg         <= '0;
            hit_reg       <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v_reg     <= v_next;
            if (pop)
            begin
                hit_reg <= 1'b0;
            end
            else if ((state_reg == S_SCAN_OFF) && match && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            voice_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= voice_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg   <= cmd.op;
            note_reg <= cmd.note;
            vel_reg  <= cmd.velocity;
            best_reg <= BUSY_INIT;
            pick_reg <= '0;
        end
        else if ((state_reg == S_SCAN_ON) && better)
        begin
            best_reg <= busy;
            pick_reg <= v_reg;
        end
        if ((state_reg == S_SCAN_OFF) && match && !hit_reg)
        begin
            hit_idx_reg <= v_reg;
            hit_rec_reg <= rec;
        end
        if (emit)
        begin
            voice_index_reg    <= 3'(emit_idx);
            found_reg          <= emit_found;
            voice_note_reg     <= emit_rec.note;
            voice_velocity_reg <= emit_rec.velocity;
            env_state_reg      <= emit_rec.state;
            env_level_reg      <= emit_rec.level;
            last_reg           <= emit_last;
        end
    end

    `PVAE_ASSERT_IMPLY(a_no_overwrite, emit && out_valid_reg, !out_stall, "result overwritten while stalled")
    `PVAE_ASSERT_IMPLY(a_level_range, out_valid_reg, env_level_reg <= LEVEL_ONE, "envelope level above one")
    `PVAE_ASSERT_IMPLY(a_empty_result, out_valid_reg && !found_reg, (voice_index_reg == 3'd0) && (voice_note_reg == 7'd0) && (env_level_reg == 16'd0) && (env_state_reg == EG_OFF), "empty result carries voice data")
    `PVAE_ASSERT_IMPLY(a_port_conflict, we && rd_en, wr_addr != rd_addr, "voice memory read and write collide")
    `PVAE_ASSERT(a_commit_done, (state_reg == S_COMMIT && out_free) |=> (state_reg == S_IDLE), "commit did not return to idle")

endmodule

[sv/poly_voice_allocator_envelope_top.sv]
// ----------------------------------------------------------------------------
// poly_voice_allocator_envelope_top
// Polyphonic voice allocator with per-voice exponential envelopes.
// ----------------------------------------------------------------------------
// Events enter on the input channel (in_valid, in_stall; kind, note, velocity)
// and results leave on the output channel (out_valid, out_stall). A transaction
// moves on a rising edge with valid high and stall low. The five envelope
// registers are written through cfg_valid/cfg_ready, cfg_index and cfg_data;
// the user must write them only while the block is idle, as the block itself
// does not enforce it; cfg_ready is always high. The input register and a
// two-entry command queue decouple the input side from the voice engine, so
// events are taken while the engine works. The engine visits one voice per
// cycle in its voice memory: a sample tick steps every voice and reports the
// first eight voices (all, if fewer) one per cycle while results are taken;
// a note-on or note-off scans all voices and then commits; an unused kind
// goes straight to the commit step, which gives an empty result.
// A stalled receiver holds the result register and halts the engine, when it
// has a result to give, until the result is taken.
// Reset restores the register defaults and marks every voice off at once.
// ----------------------------------------------------------------------------
module poly_voice_allocator_envelope_top
    import pvae_pkg::*;
#(
    parameter int VOICE_COUNT = VOICE_COUNT_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             kind,
    input  logic [6:0]             note,
    input  logic [6:0]             velocity,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             voice_index,
    output logic                   found,
    output logic [6:0]             voice_note,
    output logic [6:0]             voice_velocity,
    output logic [1:0]             env_state,
    output logic [15:0]            env_level,
    output logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    fifo_status_t status;
    logic         push;
    logic         pop;
    cmd_t         push_cmd;
    cmd_t         pop_cmd;

    pvae_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .note     (note),
        .velocity (velocity),
        .status   (status),
        .push     (push),
        .cmd      (push_cmd)
    );

    pvae_cmd_fifo u_cmd_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .status    (status)
    );

    pvae_back #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .status         (status),
        .pop            (pop),
        .cmd            (pop_cmd),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .voice_index    (voice_index),
        .found          (found),
        .voice_note     (voice_note),
        .voice_velocity (voice_velocity),
        .env_state      (env_state),
        .env_level      (env_level),
        .last           (last)
    );

endmodule

[tb/sv/voice_report_checker.sv]
// ----------------------------------------------------------------------------
// voice_report_checker
// Watches the event, result and register channels of the voice allocator,
// keeps its own copy of the voices and the envelope registers, works out the
// results that every accepted event must produce and compares each accepted
// result with the oldest one still due.
// ----------------------------------------------------------------------------
module voice_report_checker
    import pvae_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [1:0]             kind,
    input  logic [6:0]             note,
    input  logic [6:0]             velocity,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [2:0]             voice_index,
    input  logic                   found,
    input  logic [6:0]             voice_note,
    input  logic [6:0]             voice_velocity,
    input  logic [1:0]             env_state,
    input  logic [15:0]            env_level,
    input  logic                   last,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    output int                     fail_count,
    output int                     reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VOICES   = VOICE_COUNT_DEFAULT;
    localparam int REPORTED = (VOICES < MAX_REPORT) ? VOICES : MAX_REPORT;

    typedef struct packed {
        logic [2:0]  index;
        logic        found;
        logic [6:0]  note;
        logic [6:0]  velocity;
        env_t        state;
        logic [15:0] level;
        logic        last;
    } voice_report_t;

    logic [15:0]   attack_step;
    logic [15:0]   decay_coeff;
    logic [15:0]   release_coeff;
    logic [15:0]   sustain_level;
    logic [15:0]   off_threshold;
    logic [6:0]    notes      [VOICES];
    logic [6:0]    velocities [VOICES];
    env_t          states     [VOICES];
    logic [15:0]   levels     [VOICES];
    voice_report_t expected_reports[$];
    int            mismatches = 0;
    int            due_count  = 0;

    assign fail_count  = mismatches;
    assign reports_due = due_count;

    function automatic void step_envelope(int v);
        longint lv;
        longint s;
        longint diff;
        longint res;
        lv = longint'(levels[v]);
        case (states[v])
            EG_ATTACK:
            begin
                lv = lv + longint'(attack_step);
                if (lv > longint'(LEVEL_ONE))
                begin
                    lv = longint'(LEVEL_ONE);
                    states[v] = EG_HOLD;
                end
            end
            EG_HOLD:
            begin
                s = longint'(sustain_level);
                diff = lv - s;
                if (diff >= 0)
                    res = s + ((diff * longint'(decay_coeff)) >>> 16);
                else
                    res = s - (((-diff) * longint'(decay_coeff)) >>> 16);
                if (res < 0)
                    res = 0;
                if (res > longint'(LEVEL_ONE))
                    res = longint'(LEVEL_ONE);
                lv = res;
            end
            EG_RELEASE:
            begin
                lv = (lv * longint'(release_coeff)) >>> 16;
                if (lv < longint'(off_threshold))
                begin
                    lv = 0;
                    states[v] = EG_OFF;
                end
            end
            default:
            begin
            end
        endcase
        levels[v] = lv[15:0];
    endfunction

    function automatic longint business(int v);
        if (states[v] == EG_OFF)
            return 0;
        if (states[v] == EG_RELEASE)
            return longint'(levels[v]);
        return longint'(BUSY_FULL);
    endfunction

    function automatic voice_report_t report_of(int v, logic is_last);
        voice_report_t r;
        r.index    = v[2:0];
        r.found    = 1'b1;
        r.note     = notes[v];
        r.velocity = velocities[v];
        r.state    = states[v];
        r.level    = levels[v];
        r.last     = is_last;
        return r;
    endfunction

    task automatic predict_event(op_t op, logic [6:0] n, logic [6:0] vel);
        voice_report_t r;
        int            pick;
        longint        best;
        bit            done;
        r    = '0;
        pick = 0;
        best = longint'(BUSY_INIT);
        done = 1'b0;
        case (op)
            OP_TICK:
            begin
                for (int v = 0; v < VOICES; v++)
                    step_envelope(v);
                for (int v = 0; v < REPORTED; v++)
                    expected_reports.push_back(report_of(v, v == REPORTED - 1));
            end
            OP_NOTE_ON:
            begin
                for (int v = 0; v < VOICES; v++)
                begin
                    if (!done && business(v) < best)
                    begin
                        pick = v;
                        best = business(v);
                        done = (best == 0);
                    end
                end
                notes[pick]      = n;
                velocities[pick] = vel;
                states[pick]     = EG_ATTACK;
                levels[pick]     = '0;
                expected_reports.push_back(report_of(pick, 1'b1));
            end
            OP_NOTE_OFF:
            begin
                for (int v = 0; v < VOICES; v++)
                begin
                    if (!done && notes[v] == n &&
                        (states[v] == EG_ATTACK || states[v] == EG_HOLD))
                    begin
                        done = 1'b1;
                        pick = v;
                    end
                end
                if (done)
                begin
                    states[pick] = EG_RELEASE;
                    expected_reports.push_back(report_of(pick, 1'b1));
                end
                else
                begin
                    r.last = 1'b1;
                    expected_reports.push_back(r);
                end
            end
            default:
            begin
                r.last = 1'b1;
                expected_reports.push_back(r);
            end
        endcase
    endtask

    task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        voice_report_t exp_r;
        if (!rst_n)
        begin
            attack_step   = ATTACK_STEP_RST;
            decay_coeff   = DECAY_COEFF_RST;
            release_coeff = RELEASE_COEFF_RST;
            sustain_level = SUSTAIN_LEVEL_RST;
            off_threshold = OFF_THRESHOLD_RST;
            for (int v = 0; v < VOICES; v++)
            begin
                notes[v]      = '0;
                velocities[v] = '0;
                states[v]     = EG_OFF;
                levels[v]     = '0;
            end
            expected_reports.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ATTACK_STEP:   attack_step   = cfg_data;
                    CFG_DECAY_COEFF:   decay_coeff   = cfg_data;
                    CFG_RELEASE_COEFF: release_coeff = cfg_data;
                    CFG_SUSTAIN_LEVEL: sustain_level = cfg_data;
                    CFG_OFF_THRESHOLD: off_threshold = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                predict_event(op_t'(kind), note, velocity);
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected result: voice_index %0d, found %0d, level %0d",
                           voice_index, found, env_level);
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_reports.pop_front();
                    check_field("voice_index", exp_r.index, voice_index);
                    check_field("found", exp_r.found, found);
                    check_field("voice_note", exp_r.note, voice_note);
                    check_field("voice_velocity", exp_r.velocity, voice_velocity);
                    check_field("env_state", exp_r.state, env_state);
                    check_field("env_level", exp_r.level, env_level);
                    check_field("last", exp_r.last, last);
                end
            end
        end
        due_count = expected_reports.size();
    end

endmodule

[tb/sv/tb_poly_voice_allocator_envelope_top.sv]
// ----------------------------------------------------------------------------
// tb_poly_voice_allocator_envelope_top
// Drives note-on, note-off, tick and unused events into the voice allocator
// under several envelope register settings and handshake patterns, including
// a long receiver hold-off, and reports the verdict of the result checker.
// ----------------------------------------------------------------------------
module tb_poly_voice_allocator_envelope_top
    import pvae_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 300;
    localparam int TIMEOUT_CYCLES = 200000;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = CFG_OFF_THRESHOLD + 3'd1;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   in_valid       = 1'b0;
    logic                   in_stall;
    logic [1:0]             kind           = KIND_TICK;
    logic [6:0]             note           = '0;
    logic [6:0]             velocity       = '0;
    logic                   out_valid;
    logic                   out_stall      = 1'b0;
    logic [2:0]             voice_index;
    logic                   found;
    logic [6:0]             voice_note;
    logic [6:0]             voice_velocity;
    logic [1:0]             env_state;
    logic [15:0]            env_level;
    logic                   last;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [15:0]            cfg_data       = '0;

    int         fail_count;
    int         reports_due;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    logic       squeeze       = 1'b0;
    logic       squeeze_prev  = 1'b0;
    int         hold_left     = 0;
    logic [6:0] note_pool [8];

    poly_voice_allocator_envelope_top #(
        .VOICE_COUNT(VOICE_COUNT_DEFAULT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .note          (note),
        .velocity      (velocity),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .voice_index   (voice_index),
        .found         (found),
        .voice_note    (voice_note),
        .voice_velocity(voice_velocity),
        .env_state     (env_state),
        .env_level     (env_level),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    voice_report_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .note          (note),
        .velocity      (velocity),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .voice_index   (voice_index),
        .found         (found),
        .voice_note    (voice_note),
        .voice_velocity(voice_velocity),
        .env_state     (env_state),
        .env_level     (env_level),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .reports_due   (reports_due)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // A rising edge of squeeze starts one long hold-off of the result channel.
    always @(posedge clk)
    begin
        if (squeeze && !squeeze_prev)
            hold_left = LONG_HOLD;
        squeeze_prev = squeeze;
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic offer_event(op_t op, logic [6:0] n, logic [6:0] vel);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        note     <= n;
        velocity <= vel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic random_events(int count);
        int         pick;
        op_t        op;
        logic [6:0] n;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op = OP_TICK;
            else if (pick < 70)
                op = OP_NOTE_ON;
            else if (pick < 95)
                op = OP_NOTE_OFF;
            else
                op = OP_NONE;
            if ($urandom_range(0, 99) < 75)
                n = note_pool[$urandom_range(0, 7)];
            else
                n = 7'($urandom_range(0, 127));
            offer_event(op, n, 7'($urandom_range(0, 127)));
        end
    endtask

    task automatic apply_config(logic [15:0] a_step, logic [15:0] d_coeff,
                                logic [15:0] r_coeff, logic [15:0] sustain,
                                logic [15:0] threshold);
        logic [15:0] values [CFG_UNUSED + 1];
        values[CFG_ATTACK_STEP]   = a_step;
        values[CFG_DECAY_COEFF]   = d_coeff;
        values[CFG_RELEASE_COEFF] = r_coeff;
        values[CFG_SUSTAIN_LEVEL] = sustain;
        values[CFG_OFF_THRESHOLD] = threshold;
        values[CFG_UNUSED]        = 16'($urandom);
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = 0; i <= CFG_UNUSED; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data  <= values[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        note_pool[0] = 7'd0;
        note_pool[1] = 7'd127;
        for (int i = 2; i < 8; i++)
            note_pool[i] = 7'($urandom_range(1, 126));
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed events: unused kind, unmatched note-off, voice stealing,
        // the full-scale attack level and choice among releasing voices.
        apply_config(16'd32768, 16'd30000, 16'd20000, SUSTAIN_LEVEL_RST, OFF_THRESHOLD_RST);
        offer_event(OP_NONE, 7'h7f, 7'h7f);
        offer_event(OP_NOTE_OFF, 7'd0, 7'd0);
        offer_event(OP_TICK, 7'd0, 7'd0);
        for (int i = 0; i < 8; i++)
            offer_event(OP_NOTE_ON, note_pool[i], (i % 2 == 1) ? 7'd127 : 7'd0);
        offer_event(OP_NOTE_ON, 7'd64, 7'd1);
        offer_event(OP_TICK, 7'd0, 7'd0);
        offer_event(OP_TICK, 7'd0, 7'd0);
        offer_event(OP_TICK, 7'd0, 7'd0);
        offer_event(OP_NOTE_OFF, 7'd127, 7'd0);
        offer_event(OP_NOTE_OFF, note_pool[2], 7'd0);
        offer_event(OP_TICK, 7'd0, 7'd0);
        offer_event(OP_NOTE_ON, 7'd60, 7'd100);
        offer_event(OP_NOTE_OFF, 7'd127, 7'd0);
        offer_event(OP_NOTE_OFF, 7'd0, 7'd0);
        offer_event(OP_TICK, 7'd0, 7'd0);

        apply_config(16'd4096, 16'd40000, 16'd45000, 16'd12000, 16'd200);
        random_events(45);

        send_idle_pct = 66;
        apply_config(16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        random_events(40);

        send_idle_pct = 0;
        stall_pct     = 66;
        apply_config(16'd32768, 16'd65535, 16'd65535, 16'd32768, 16'd32768);
        random_events(45);

        send_idle_pct = 13;
        stall_pct     = 13;
        apply_config(16'($urandom_range(1024, 32768)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 60000)), 16'($urandom_range(0, 32768)),
                     16'($urandom_range(0, 2000)));
        random_events(45);

        send_idle_pct = 0;
        stall_pct     = 0;
        apply_config(16'($urandom_range(2048, 32768)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 50000)), 16'($urandom_range(0, 32768)),
                     16'($urandom_range(0, 500)));
        squeeze <= 1'b1;
        random_events(40);
        squeeze <= 1'b0;

        send_idle_pct = 13;
        stall_pct     = 13;
        apply_config(16'($urandom_range(1, 32768)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 32768)),
                     16'($urandom_range(0, 32768)));
        random_events(45);

        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && reports_due == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
